@@ design/scfla_pkg.sv @@
// ----------------------------------------------------------------------------
// scfla_pkg
// Shared types, constants and the size classifier for the size class
// free list allocator.
// ----------------------------------------------------------------------------
package scfla_pkg;

  // Arena geometry
  localparam int ADDR_W         = 20;
  localparam int ADDR_SPACE     = 1 << ADDR_W;
  localparam int MIN_BLOCK_LOG2 = 3;
  localparam int MIN_BLOCK_BYTES = 1 << MIN_BLOCK_LOG2;
  localparam int SLOT_W         = ADDR_W - MIN_BLOCK_LOG2;
  localparam int LINK_SLOTS     = 1 << SLOT_W;
  localparam int LINK_W         = 18;
  localparam int CHUNK_LOG2     = 15;
  localparam int CHUNK_BYTES    = 1 << CHUNK_LOG2;
  localparam int ARENA_CHUNKS   = 32;
  localparam int FIT_CHUNKS     = ADDR_SPACE / CHUNK_BYTES;
  localparam int USABLE_CHUNKS  = (FIT_CHUNKS < ARENA_CHUNKS) ? FIT_CHUNKS : ARENA_CHUNKS;
  localparam int CHUNK_IDX_W    = 6;
  localparam int NUM_CLASSES    = 12;
  localparam int CLASS_W        = 4;
  localparam int OFFSET_W       = CHUNK_LOG2 + 2;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERSIZE = 2'd1,
    ST_WRONG    = 2'd2,
    ST_NOMEM    = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [ADDR_W-1:0]   request_size;
    logic [ADDR_W-1:0]   block_address;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   granted_address;
    logic [CLASS_W-1:0]  size_class;
  } rsp_t;

  typedef struct packed {
    status_t             status;
    logic [CLASS_W-1:0]  cls;
  } class_t;

  // Round a byte size up to its class; flag zero and oversize requests
  function automatic class_t classify(input logic [ADDR_W-1:0] size);
    class_t res;
    longint csz;
    res.status = ST_WRONG;
    res.cls    = '0;
    if (size == '0) begin
      res.status = ST_WRONG;
    end else if (longint'(size) * 2 > longint'(CHUNK_BYTES)) begin
      res.status = ST_OVERSIZE;
    end else begin
      // Walk downwards so the smallest fitting class wins
      for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
        csz = longint'(MIN_BLOCK_BYTES) << k;
        if ((csz * 2 <= longint'(CHUNK_BYTES)) && (longint'(size) <= csz)) begin
          res.status = ST_OK;
          res.cls    = CLASS_W'(k);
        end
      end
    end
    return res;
  endfunction

endpackage

@@ design/size_class_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// size_class_free_list_allocator
// Power-of-two size class allocator over a fixed arena, with one LIFO free
// list per class kept as links in a synchronous link memory.
//
// Usage:
//   Request channel (req_valid / req_stall / req): each request is either
//   an allocation or a free of a block of request_size bytes. A free gives
//   the block's byte offset in block_address.
//   Response channel (rsp_valid / rsp_stall / rsp): exactly one response per
//   request, in request order, carrying status, granted_address and the
//   size class.
//   An accepted request is latched in req_q and its response registered in rsp
//   once it executes; no new request is taken until then. The accept cycle
//   reads the class head and issues the link memory read, the execute cycle
//   uses the read data and writes the memory and class registers back.
//   A response waits in the output register while the next request is
//   accepted; if it is still stalled when that request finishes executing,
//   execution holds and req_stall stays high.
//   Reset clears the class heads, cursors and chunk counter; the link memory
//   is left as is and needs no clearing pass.
// ----------------------------------------------------------------------------
module size_class_free_list_allocator (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  scfla_pkg::req_t   req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output scfla_pkg::rsp_t   rsp
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Class state
  logic [scfla_pkg::LINK_W-1:0]      class_head   [scfla_pkg::NUM_CLASSES];
  logic [scfla_pkg::ADDR_W-1:0]      class_cursor [scfla_pkg::NUM_CLASSES];
  logic [scfla_pkg::NUM_CLASSES-1:0] cursor_valid;
  logic [scfla_pkg::CHUNK_IDX_W-1:0] next_free_chunk;
  logic [scfla_pkg::CHUNK_IDX_W-1:0] next_free_chunk_next;

  // Link memory
  logic [scfla_pkg::LINK_W-1:0] link_mem [scfla_pkg::LINK_SLOTS];
  logic                         mem_re;
  logic [scfla_pkg::SLOT_W-1:0] mem_raddr;
  logic [scfla_pkg::LINK_W-1:0] mem_rdata;
  logic                         mem_we;
  logic [scfla_pkg::SLOT_W-1:0] mem_waddr;
  logic [scfla_pkg::LINK_W-1:0] mem_wdata;

  // Latched request
  scfla_pkg::req_t   req_q;
  scfla_pkg::class_t cls_q;
  scfla_pkg::class_t cls_in;

  // Execute-stage controls
  logic                          accept;
  logic                          go;
  logic                          head_we;
  logic [scfla_pkg::LINK_W-1:0]  head_wval;
  logic                          cursor_we;
  logic [scfla_pkg::ADDR_W-1:0]  cursor_wval;
  logic                          cursor_valid_wval;
  scfla_pkg::rsp_t               rsp_next;

  logic [scfla_pkg::LINK_W-1:0]   head;
  logic [scfla_pkg::SLOT_W-1:0]   head_slot;
  logic [scfla_pkg::ADDR_W-1:0]   bsz;
  logic [scfla_pkg::ADDR_W-1:0]   base;
  logic [scfla_pkg::OFFSET_W-1:0] fill_end;
  logic [scfla_pkg::SLOT_W-1:0]   free_slot;

  // Accept a request only between executions
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign go        = (state == S_EXEC) && !(rsp_valid && rsp_stall);
  assign cls_in    = scfla_pkg::classify(req.request_size);

  // Issue the head link read at accept
  assign mem_re    = accept;
  assign mem_raddr = scfla_pkg::SLOT_W'(class_head[cls_in.cls] - scfla_pkg::LINK_W'(1));

  // Sequence the two steps
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_EXEC;
      S_EXEC:  if (go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Execute: pop, carve from the cursor, or push
  always_comb begin
    head      = class_head[cls_q.cls];
    head_slot = scfla_pkg::SLOT_W'(head - scfla_pkg::LINK_W'(1));
    bsz       = scfla_pkg::ADDR_W'(scfla_pkg::MIN_BLOCK_BYTES) << cls_q.cls;
    free_slot = req_q.block_address[scfla_pkg::ADDR_W-1:scfla_pkg::MIN_BLOCK_LOG2];
    base      = class_cursor[cls_q.cls];
    fill_end  = '0;

    head_we              = 1'b0;
    head_wval            = mem_rdata;
    cursor_we            = 1'b0;
    cursor_wval          = '0;
    cursor_valid_wval    = 1'b0;
    mem_we               = 1'b0;
    mem_waddr            = free_slot;
    mem_wdata            = head;
    next_free_chunk_next = next_free_chunk;

    rsp_next.status          = cls_q.status;
    rsp_next.granted_address = '0;
    rsp_next.size_class      = (cls_q.status == scfla_pkg::ST_OK) ? cls_q.cls : '0;

    if (cls_q.status == scfla_pkg::ST_OK) begin
      if (req_q.opcode == scfla_pkg::OP_ALLOC) begin
        if (head != '0) begin
          // Pop the free list head
          head_we                  = 1'b1;
          head_wval                = mem_rdata;
          rsp_next.granted_address = {head_slot, {scfla_pkg::MIN_BLOCK_LOG2{1'b0}}};
        end else begin
          // Take the next block of the current chunk, carving one if needed
          if (!cursor_valid[cls_q.cls]) begin
            base = scfla_pkg::ADDR_W'(next_free_chunk) << scfla_pkg::CHUNK_LOG2;
          end
          if (!cursor_valid[cls_q.cls] &&
              (next_free_chunk >= scfla_pkg::CHUNK_IDX_W'(scfla_pkg::USABLE_CHUNKS))) begin
            rsp_next.status = scfla_pkg::ST_NOMEM;
          end else begin
            if (!cursor_valid[cls_q.cls]) begin
              next_free_chunk_next = next_free_chunk + scfla_pkg::CHUNK_IDX_W'(1);
            end
            fill_end = scfla_pkg::OFFSET_W'(base[scfla_pkg::CHUNK_LOG2-1:0])
                     + scfla_pkg::OFFSET_W'({bsz, 1'b0});
            cursor_we                = 1'b1;
            cursor_wval              = base + bsz;
            cursor_valid_wval        = (fill_end <= scfla_pkg::OFFSET_W'(scfla_pkg::CHUNK_BYTES));
            rsp_next.granted_address = base;
          end
        end
      end else begin
        // Push the freed block
        mem_we    = 1'b1;
        mem_wdata = head;
        head_we   = 1'b1;
        head_wval = scfla_pkg::LINK_W'(free_slot) + scfla_pkg::LINK_W'(1);
      end
    end
  end

  // Link memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (go && mem_we) link_mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata <= link_mem[mem_raddr];
  end

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
      cls_q <= cls_in;
    end
  end

  // Control and class state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      cursor_valid    <= '0;
      next_free_chunk <= '0;
      rsp_valid       <= 1'b0;
      for (int k = 0; k < scfla_pkg::NUM_CLASSES; k++) begin
        class_head[k]   <= '0;
        class_cursor[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (go) begin
        next_free_chunk <= next_free_chunk_next;
        if (head_we) class_head[cls_q.cls] <= head_wval;
        if (cursor_we) begin
          class_cursor[cls_q.cls] <= cursor_wval;
          cursor_valid[cls_q.cls] <= cursor_valid_wval;
        end
      end
      // Load the response, or drop it once taken
      if (go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (go) rsp <= rsp_next;
  end

endmodule
